FILE: design/ahps_pkg.sv
package ahps_pkg;

   localparam int MAX_LANES   = 4;
   localparam int LAYER_ID_W  = 8;
   localparam int PHASE_W     = 4;
   localparam int OP_W        = 3;
   localparam int SLOTS       = 7;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 40;

   localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
   localparam logic [PHASE_W-1:0] PH_Q         = 4'd1;
   localparam logic [PHASE_W-1:0] PH_K         = 4'd2;
   localparam logic [PHASE_W-1:0] PH_K_REQ     = 4'd3;
   localparam logic [PHASE_W-1:0] PH_K_WB      = 4'd4;
   localparam logic [PHASE_W-1:0] PH_V         = 4'd5;
   localparam logic [PHASE_W-1:0] PH_V_REQ     = 4'd6;
   localparam logic [PHASE_W-1:0] PH_V_WB      = 4'd7;
   localparam logic [PHASE_W-1:0] PH_Q_REQ     = 4'd8;
   localparam logic [PHASE_W-1:0] PH_SCORES    = 4'd9;
   localparam logic [PHASE_W-1:0] PH_SCALE     = 4'd10;
   localparam logic [PHASE_W-1:0] PH_SOFTMAX   = 4'd11;
   localparam logic [PHASE_W-1:0] PH_ATT_VAL   = 4'd12;
   localparam logic [PHASE_W-1:0] PH_REQUANT   = 4'd13;
   localparam logic [PHASE_W-1:0] PH_DONE      = 4'd14;

   localparam logic [OP_W-1:0] OP_NONE = 3'd0;

   typedef struct packed {
      logic            hit;
      logic [OP_W-1:0] idx;
   } ahps_slot_type;

   typedef struct packed {
      logic               fire;
      logic [OP_W-1:0]    op;
      logic [PHASE_W-1:0] phase;
   } ahps_lane_out_type;

   function automatic ahps_slot_type slot_of(input logic [PHASE_W-1:0] ph);
      ahps_slot_type s;
      s.hit = 1'b1;
      unique case (ph)
         PH_Q:       s.idx = 3'd0;
         PH_K:       s.idx = 3'd1;
         PH_V:       s.idx = 3'd2;
         PH_SCORES:  s.idx = 3'd3;
         PH_SCALE:   s.idx = 3'd4;
         PH_SOFTMAX: s.idx = 3'd5;
         PH_ATT_VAL: s.idx = 3'd6;
         default: begin
            s.hit = 1'b0;
            s.idx = 3'd0;
         end
      endcase
      return s;
   endfunction

   function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] ph);
      return (ph < PH_DONE) ? ph + 4'd1 : ph;
   endfunction

endpackage

FILE: design/ahps_lane.sv
module ahps_lane
   import ahps_pkg::*;
#(
   parameter int LAYER_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [LAYER_BITS-1:0] layer,
   input  logic                  start,
   input  logic                  rdy,
   input  logic                  dn,
   output ahps_lane_out_type     lane_out
);

   logic [PHASE_W-1:0]    phase_ff, phase_in;
   logic [LAYER_BITS-1:0] stamp_ff, stamp_in;
   logic [SLOTS-1:0]      started_ff, started_in;
   logic [SLOTS-1:0]      done_ff, done_in;

   logic               chg;
   logic               kick;
   logic               rdy_eff;
   logic               dn_eff;
   logic               fire;
   logic [OP_W-1:0]    op;
   logic [PHASE_W-1:0] ph;
   ahps_slot_type      slot;
   logic [SLOTS-1:0]   bitsel;

   always_comb begin
      phase_in   = phase_ff;
      stamp_in   = stamp_ff;
      started_in = started_ff;
      done_in    = done_ff;
      fire       = 1'b0;
      op         = OP_NONE;
      ph         = phase_ff;
      chg        = stamp_ff != layer;
      kick       = start && (phase_ff == PH_IDLE);
      rdy_eff    = rdy && !chg;
      dn_eff     = dn && !chg;
      slot       = '0;
      bitsel     = '0;
      if (phase_ff != PH_DONE) begin
         if (chg) begin
            stamp_in   = layer;
            ph         = PH_IDLE;
            started_in = '0;
            done_in    = '0;
         end
         if (dn_eff) begin
            done_in = done_in | started_in;
         end
         slot   = slot_of(ph);
         bitsel = SLOTS'(1) << slot.idx;
         if (ph == PH_IDLE) begin
            if (kick) begin
               started_in = '0;
               done_in    = '0;
               ph         = PH_Q;
            end
         end else if (slot.hit) begin
            if (rdy_eff && !(|(started_in & bitsel))) begin
               fire       = 1'b1;
               op         = slot.idx + 3'd1;
               started_in = started_in | bitsel;
            end else if ((|(done_in & bitsel)) && (|(started_in & bitsel))) begin
               ph         = next_phase(ph);
               started_in = started_in & ~bitsel;
            end
         end else begin
            ph = next_phase(ph);
         end
         phase_in = ph;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         stamp_ff   <= '0;
         started_ff <= '0;
         done_ff    <= '0;
      end else if (step_en) begin
         phase_ff   <= phase_in;
         stamp_ff   <= stamp_in;
         started_ff <= started_in;
         done_ff    <= done_in;
      end
   end

   assign lane_out.fire  = fire;
   assign lane_out.op    = op;
   assign lane_out.phase = phase_in;

endmodule

FILE: design/attention_head_phase_sequencer.sv
// rsp_tvalid rises once an item has passed the input register (loaded at the req_ transfer
// edge) and the result register (loaded as the item leaves the input register); lane state
// updates as the item leaves the input register.
// Throughput: 1 item per cycle; req_tready stays high while rsp_tready is high.
// A stalled result register holds one item and the input register holds one more.
// Reset (synchronous, active high) puts every lane in idle with stamp and flags clear
// and empties both registers.
module attention_head_phase_sequencer
   import ahps_pkg::*;
#(
   parameter int LANES      = 4,
   parameter int LAYER_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] layer_id, [8] start_req, [12:9] ready_mask, [16:13] done_mask, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] start_mask, [15:4] op_codes, [31:16] lane_phases, [32] all_lanes_done,
   // rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int EXT_W = (LAYER_BITS > LAYER_ID_W) ? LAYER_BITS : LAYER_ID_W;

   logic                  s1_valid_ff, s1_valid_in;
   logic [LAYER_ID_W-1:0] s1_layer_ff;
   logic                  s1_start_ff;
   logic [MAX_LANES-1:0]  s1_ready_ff;
   logic [MAX_LANES-1:0]  s1_done_ff;
   logic                  s1_adv;
   logic [EXT_W-1:0]      layer_ext;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [MAX_LANES-1:0]        smask_ff;
   logic [MAX_LANES*OP_W-1:0]   ops_ff;
   logic [MAX_LANES*PHASE_W-1:0] phases_ff;
   logic                        finished_ff;

   logic [MAX_LANES-1:0]         smask_c;
   logic [MAX_LANES*OP_W-1:0]    ops_c;
   logic [MAX_LANES*PHASE_W-1:0] phases_c;
   logic [MAX_LANES-1:0]         lane_done;

   ahps_lane_out_type lane_out [MAX_LANES];

   assign s1_adv      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_adv;
   assign s1_valid_in = (req_tvalid && req_tready) || (s1_valid_ff && !s1_adv);
   assign layer_ext   = EXT_W'(s1_layer_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_layer_ff <= req_tdata[7:0];
         s1_start_ff <= req_tdata[8];
         s1_ready_ff <= req_tdata[12:9];
         s1_done_ff  <= req_tdata[16:13];
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_LANES; g++) begin : g_lane
         if (g < LANES) begin : g_on
            ahps_lane #(
               .LAYER_BITS (LAYER_BITS)
            ) u_lane (
               .clock    (clock),
               .reset    (reset),
               .step_en  (s1_adv),
               .layer    (layer_ext[LAYER_BITS-1:0]),
               .start    (s1_start_ff),
               .rdy      (s1_ready_ff[g]),
               .dn       (s1_done_ff[g]),
               .lane_out (lane_out[g])
            );
            assign lane_done[g] = lane_out[g].phase == PH_DONE;
         end else begin : g_off
            assign lane_out[g]  = '0;
            assign lane_done[g] = 1'b1;
         end
         assign smask_c[g]                      = lane_out[g].fire;
         assign ops_c[g*OP_W +: OP_W]           = lane_out[g].op;
         assign phases_c[g*PHASE_W +: PHASE_W]  = lane_out[g].phase;
      end
   endgenerate

   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         smask_ff    <= smask_c;
         ops_ff      <= ops_c;
         phases_ff   <= phases_c;
         finished_ff <= &lane_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, finished_ff, phases_ff, ops_ff, smask_ff};

endmodule

FILE: design/ahps_checker.sv
module ahps_checker
   import ahps_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_start_op: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[6:4] != 3'd0))
                  && (rsp_tdata[1] == (rsp_tdata[9:7] != 3'd0))
                  && (rsp_tdata[2] == (rsp_tdata[12:10] != 3'd0))
                  && (rsp_tdata[3] == (rsp_tdata[15:13] != 3'd0)))
      else $error("start bit and op code disagree");

   a_finished_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> rsp_tdata[3:0] == 4'd0)
      else $error("finished group still launches work");

endmodule

bind attention_head_phase_sequencer ahps_checker u_ahps_checker (.*);

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
   import ahps_pkg::*;

   localparam logic [OP_W-1:0] OP_Q       = 3'd1;
   localparam logic [OP_W-1:0] OP_K       = 3'd2;
   localparam logic [OP_W-1:0] OP_V       = 3'd3;
   localparam logic [OP_W-1:0] OP_SCORES  = 3'd4;
   localparam logic [OP_W-1:0] OP_SCALE   = 3'd5;
   localparam logic [OP_W-1:0] OP_SOFTMAX = 3'd6;
   localparam logic [OP_W-1:0] OP_ATT_VAL = 3'd7;

   localparam int STUCK_LIMIT    = 5000;
   localparam int MAX_REPORTED   = 10;
   localparam logic [LAYER_ID_W-1:0] LAYER_MAX = '1;
   localparam logic [MAX_LANES-1:0] ALL_LANES = '1;

   typedef struct packed {
      logic [MAX_LANES-1:0]  done_mask;
      logic [MAX_LANES-1:0]  ready_mask;
      logic                  start_req;
      logic [LAYER_ID_W-1:0] layer_id;
   } lane_step_type;

   typedef struct packed {
      logic                          all_lanes_done;
      logic [MAX_LANES*PHASE_W-1:0]  lane_phases;
      logic [MAX_LANES*OP_W-1:0]     op_codes;
      logic [MAX_LANES-1:0]          start_mask;
   } lane_report_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   logic [PHASE_W-1:0]    lane_phase [MAX_LANES] = '{default: PH_IDLE};
   logic [LAYER_ID_W-1:0] lane_layer [MAX_LANES] = '{default: '0};
   logic [SLOTS-1:0]      launched_ops [MAX_LANES] = '{default: '0};
   logic [SLOTS-1:0]      completed_ops [MAX_LANES] = '{default: '0};
   logic [LAYER_ID_W-1:0] layer_now = '0;

   lane_report_type expected_reports [$];
   int  mismatch_count = 0;
   int  stuck_cycles = 0;
   int  stall_left = 0;
   bit  sender_gaps_on = 1'b0;
   bit  sink_stalls_on = 1'b0;

   attention_head_phase_sequencer #(
      .LANES      (MAX_LANES),
      .LAYER_BITS (LAYER_ID_W)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int pick_gap(bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 60) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(5, 20);
   endfunction

   function automatic logic [OP_W-1:0] phase_op(logic [PHASE_W-1:0] ph);
      case (ph)
         PH_Q:       return OP_Q;
         PH_K:       return OP_K;
         PH_V:       return OP_V;
         PH_SCORES:  return OP_SCORES;
         PH_SCALE:   return OP_SCALE;
         PH_SOFTMAX: return OP_SOFTMAX;
         PH_ATT_VAL: return OP_ATT_VAL;
         default:    return OP_NONE;
      endcase
   endfunction

   function automatic lane_report_type predict_lane_step(lane_step_type s);
      lane_report_type    r;
      logic [PHASE_W-1:0] ph;
      logic [OP_W-1:0]    code;
      logic [OP_W-1:0]    op;
      logic [SLOTS-1:0]   op_bit;
      logic               rdy;
      logic               dn;
      logic               kick;
      logic               fire;
      int                 l;
      r = '0;
      r.all_lanes_done = 1'b1;
      for (l = 0; l < MAX_LANES; l++) begin
         ph   = lane_phase[l];
         rdy  = s.ready_mask[l];
         dn   = s.done_mask[l];
         fire = 1'b0;
         op   = OP_NONE;
         if (ph != PH_DONE) begin
            kick = s.start_req && (ph == PH_IDLE);
            if (lane_layer[l] != s.layer_id) begin
               lane_layer[l]    = s.layer_id;
               ph               = PH_IDLE;
               launched_ops[l]  = '0;
               completed_ops[l] = '0;
               rdy              = 1'b0;
               dn               = 1'b0;
            end
            if (dn) begin
               completed_ops[l] = completed_ops[l] | launched_ops[l];
            end
            code = phase_op(ph);
            if (ph == PH_IDLE) begin
               if (kick) begin
                  launched_ops[l]  = '0;
                  completed_ops[l] = '0;
                  ph               = PH_Q;
               end
            end else if (code != OP_NONE) begin
               op_bit = SLOTS'(1) << (code - OP_Q);
               if (rdy && !(launched_ops[l] & op_bit)) begin
                  fire            = 1'b1;
                  op              = code;
                  launched_ops[l] = launched_ops[l] | op_bit;
               end else if (completed_ops[l] & launched_ops[l] & op_bit) begin
                  ph              = ph + 1'b1;
                  launched_ops[l] = launched_ops[l] & ~op_bit;
               end
            end else if (ph < PH_DONE) begin
               ph = ph + 1'b1;
            end
            lane_phase[l] = ph;
         end
         if (ph != PH_DONE) begin
            r.all_lanes_done = 1'b0;
         end
         r.start_mask[l]                 = fire;
         r.op_codes[OP_W*l +: OP_W]       = op;
         r.lane_phases[PHASE_W*l +: PHASE_W] = ph;
      end
      return r;
   endfunction

   function automatic lane_step_type make_step(logic [LAYER_ID_W-1:0] layer, logic start,
                                               logic [MAX_LANES-1:0] ready,
                                               logic [MAX_LANES-1:0] done);
      lane_step_type s;
      s.layer_id   = layer;
      s.start_req  = start;
      s.ready_mask = ready;
      s.done_mask  = done;
      return s;
   endfunction

   // change layer now and then; with hold_back, also reset lanes about to finish
   function automatic lane_step_type random_step(bit hold_back, int change_pct);
      logic [LAYER_ID_W-1:0] layer;
      bit                    change;
      int                    l;
      layer  = layer_now;
      change = ($urandom_range(0, 99) < change_pct);
      for (l = 0; l < MAX_LANES; l++) begin
         if (hold_back && lane_phase[l] == PH_REQUANT) begin
            change = 1'b1;
         end
      end
      if (change) begin
         do begin
            layer = LAYER_ID_W'($urandom_range(0, LAYER_MAX));
         end while (layer == layer_now);
      end
      return make_step(layer, 1'($urandom_range(0, 1)),
                       MAX_LANES'($urandom_range(0, ALL_LANES)),
                       MAX_LANES'($urandom_range(0, ALL_LANES)));
   endfunction

   task automatic send_step(lane_step_type s);
      int gap;
      gap = pick_gap(sender_gaps_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'(s);
      do @(posedge clock); while (!req_tready);
      layer_now = s.layer_id;
      expected_reports.push_back(predict_lane_step(s));
   endtask

   task automatic drain_reports();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_reports.size() != 0);
   endtask

   task automatic test_directed_walk();
      int n;
      sender_gaps_on = 1'b0;
      sink_stalls_on = 1'b0;
      send_step(make_step('0, 1'b0, '0, '0));
      send_step(make_step(LAYER_MAX, 1'b1, ALL_LANES, ALL_LANES));
      for (n = 0; n < 19; n++) begin
         send_step(make_step(LAYER_MAX, 1'b0, ALL_LANES, ALL_LANES));
      end
      send_step(make_step('0, 1'b1, ALL_LANES, ALL_LANES));
      send_step(make_step('0, 1'b1, 4'b0101, 4'b1010));
      send_step(make_step('0, 1'b0, 4'b0101, '0));
      send_step(make_step(8'h80, 1'b1, ALL_LANES, ALL_LANES));
   endtask

   task automatic test_random_interrupted();
      int n;
      for (n = 0; n < 300; n++) begin
         sender_gaps_on = (n >= 80);
         sink_stalls_on = (n >= 80);
         send_step(random_step(1'b1, ((n % 100) >= 85) ? 30 : 3));
      end
   endtask

   task automatic test_random_finishing();
      int n;
      for (n = 0; n < 150; n++) begin
         send_step(random_step(1'b0, 5));
      end
   endtask

   task automatic test_group_finish();
      int n;
      drain_reports();
      for (n = 0; n < 24; n++) begin
         send_step(make_step(layer_now, 1'b1, ALL_LANES, ALL_LANES));
      end
      for (n = 0; n < 6; n++) begin
         send_step(random_step(1'b0, 50));
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 99) < 20) begin
         stall_left <= pick_gap(1'b1);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         if (mismatch_count < MAX_REPORTED) begin
            $display("mismatch in %s: expected %0h, got %0h", name, want, got);
         end
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      lane_report_type want;
      lane_report_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            if (mismatch_count < MAX_REPORTED) begin
               $display("unexpected result transfer: %0h", rsp_tdata);
            end
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            got  = lane_report_type'(rsp_tdata[$bits(lane_report_type)-1:0]);
            check_field("start_mask", 64'(want.start_mask), 64'(got.start_mask));
            check_field("op_codes", 64'(want.op_codes), 64'(got.op_codes));
            check_field("lane_phases", 64'(want.lane_phases), 64'(got.lane_phases));
            check_field("all_lanes_done", 64'(want.all_lanes_done),
                        64'(got.all_lanes_done));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_walk();
      drain_reports();
      test_random_interrupted();
      test_random_finishing();
      test_group_finish();
      drain_reports();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
